// ----- hdl/sst_pkg.sv -----
package sst_pkg;

  localparam int unsigned FIELD_W = 11;

  localparam logic CMD_MOVE   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  localparam logic [FIELD_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MV_RD,
    ST_MV_WR0,
    ST_MV_WR1,
    ST_LOC_WALK,
    ST_LOC_DONE
  } sst_state_e;

  typedef struct packed {
    logic clearing;
    logic moving;
    logic locating;
  } sst_status_t;

endpackage

// ----- hdl/sst_ram.sv -----
module sst_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hdl/sst_ctrl.sv -----
module sst_ctrl #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [sst_pkg::FIELD_W-1:0]            count_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic [sst_pkg::FIELD_W-1:0]            from_stack_i,
  input  logic [sst_pkg::FIELD_W-1:0]            to_stack_i,
  input  logic [sst_pkg::FIELD_W-1:0]            item_id_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [sst_pkg::FIELD_W-1:0]            holding_stack_o,
  output logic                                   top_we_o,
  output logic [$clog2(MAX_ITEMS)-1:0]           top_waddr_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0]         top_wdata_o,
  output logic [$clog2(MAX_ITEMS)-1:0]           top_raddr_o,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]         top_rdata_i,
  output logic                                   below_we_o,
  output logic [$clog2(MAX_ITEMS)-1:0]           below_waddr_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0]         below_wdata_o,
  output logic [$clog2(MAX_ITEMS)-1:0]           below_raddr_o,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]         below_rdata_i,
  output sst_pkg::sst_status_t                   status_o
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int IW = $clog2(MAX_ITEMS + 1);
  localparam int FW = sst_pkg::FIELD_W;

  sst_pkg::sst_state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;
  logic [FW-1:0] hold_q, hold_d;
  logic [FW-1:0] f_q, f_d, t_q, t_d, x_q, x_d;
  logic [IW-1:0] saved_q, saved_d, bx_q, bx_d;
  logic [FW-1:0] s_q, s_d;
  logic [IW-1:0] steps_q, steps_d;
  logic          src_top_q, src_top_d;
  logic [FW-1:0] found_q, found_d;

  logic [IW-1:0] cur;
  logic          cur_end, cur_hit, last_stack;
  logic [FW-1:0] lim;
  logic          in_accept, move_ok, loc_ok;

  assign cur        = src_top_q ? top_rdata_i : below_rdata_i;
  assign cur_end    = (cur == '0) || (32'(cur) > MAX_ITEMS) || (32'(steps_q) == MAX_ITEMS);
  assign cur_hit    = !cur_end && (32'(cur) == 32'(x_q));
  assign lim        = (32'(count_i) > MAX_ITEMS) ? FW'(MAX_ITEMS) : count_i;
  assign last_stack = (s_q == lim);

  assign in_accept = in_valid_i && !in_stall_o;
  assign move_ok   = (from_stack_i != '0) && (32'(from_stack_i) <= MAX_ITEMS)
                  && (to_stack_i != '0) && (32'(to_stack_i) <= MAX_ITEMS)
                  && (item_id_i != '0) && (32'(item_id_i) <= MAX_ITEMS);
  assign loc_ok    = (item_id_i != '0) && (32'(item_id_i) <= MAX_ITEMS) && (lim != '0);

  assign in_stall_o      = (state_q != sst_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign holding_stack_o = hold_q;

  assign status_o.clearing = (state_q == sst_pkg::ST_CLEAR);
  assign status_o.moving   = (state_q == sst_pkg::ST_MV_RD) || (state_q == sst_pkg::ST_MV_WR0)
                          || (state_q == sst_pkg::ST_MV_WR1);
  assign status_o.locating = (state_q == sst_pkg::ST_LOC_WALK)
                          || (state_q == sst_pkg::ST_LOC_DONE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    hold_d      = hold_q;
    f_d         = f_q;
    t_d         = t_q;
    x_d         = x_q;
    saved_d     = saved_q;
    bx_d        = bx_q;
    s_d         = s_q;
    steps_d     = steps_q;
    src_top_d   = src_top_q;
    found_d     = found_q;

    top_we_o      = 1'b0;
    top_waddr_o   = AW'(f_q - FW'(1));
    top_wdata_o   = bx_q;
    top_raddr_o   = AW'(t_q - FW'(1));
    below_we_o    = 1'b0;
    below_waddr_o = AW'(x_q - FW'(1));
    below_wdata_o = (f_q == t_q) ? bx_q : top_rdata_i;
    below_raddr_o = AW'(cur - IW'(1));

    case (state_q)
      sst_pkg::ST_CLEAR: begin
        top_we_o      = 1'b1;
        top_waddr_o   = clr_q;
        top_wdata_o   = IW'(clr_q) + IW'(1);
        below_we_o    = 1'b1;
        below_waddr_o = clr_q;
        below_wdata_o = '0;
        clr_d         = clr_q + AW'(1);
        if (clr_q == AW'(MAX_ITEMS - 1)) begin
          state_d = sst_pkg::ST_IDLE;
        end
      end
      sst_pkg::ST_IDLE: begin
        if (in_accept) begin
          f_d = from_stack_i;
          t_d = to_stack_i;
          x_d = item_id_i;
          if (command_i == sst_pkg::CMD_MOVE) begin
            top_raddr_o   = AW'(from_stack_i - FW'(1));
            below_raddr_o = AW'(item_id_i - FW'(1));
            if (move_ok) begin
              state_d = sst_pkg::ST_MV_RD;
            end
          end else begin
            found_d     = '0;
            top_raddr_o = '0;
            s_d         = FW'(1);
            src_top_d   = 1'b1;
            steps_d     = '0;
            state_d     = loc_ok ? sst_pkg::ST_LOC_WALK : sst_pkg::ST_LOC_DONE;
          end
        end
      end
      sst_pkg::ST_MV_RD: begin
        saved_d = top_rdata_i;
        bx_d    = below_rdata_i;
        state_d = sst_pkg::ST_MV_WR0;
      end
      sst_pkg::ST_MV_WR0: begin
        top_we_o   = 1'b1;
        below_we_o = 1'b1;
        state_d    = sst_pkg::ST_MV_WR1;
      end
      sst_pkg::ST_MV_WR1: begin
        top_we_o    = 1'b1;
        top_waddr_o = AW'(t_q - FW'(1));
        top_wdata_o = saved_q;
        state_d     = sst_pkg::ST_IDLE;
      end
      sst_pkg::ST_LOC_WALK: begin
        if (cur_hit) begin
          found_d = s_q;
        end
        if (cur_end || cur_hit) begin
          if (last_stack) begin
            state_d = sst_pkg::ST_LOC_DONE;
          end else begin
            top_raddr_o = AW'(s_q);
            s_d         = s_q + FW'(1);
            src_top_d   = 1'b1;
            steps_d     = '0;
          end
        end else begin
          src_top_d = 1'b0;
          steps_d   = steps_q + IW'(1);
        end
      end
      sst_pkg::ST_LOC_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          hold_d      = found_q;
          state_d     = sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q    <= hold_d;
    f_q       <= f_d;
    t_q       <= t_d;
    x_q       <= x_d;
    saved_q   <= saved_d;
    bx_q      <= bx_d;
    s_q       <= s_d;
    steps_q   <= steps_d;
    src_top_q <= src_top_d;
    found_q   <= found_d;
  end

endmodule

// ----- hdl/stack_segment_splice_table_top.sv -----
// Stacks of numbered items kept as linked lists in two single-port-read memories:
// one holds the top item of each stack, the other the item below each item.
// After reset the block runs a clearing pass over all MAX_ITEMS entries (stack i
// gets item i, nothing below) and stalls its input until the pass is done. A move
// reads the source top and the item's link in its accept cycle, then reads the
// destination top, then writes the new source top and the item's link, and last
// the destination top, since each memory has one write port. A locate walks the
// list of each stack scanned, up to min(count_in_use, MAX_ITEMS) stacks; the walk
// reads one entry per cycle. A located result sits in an output register, so the
// next transaction is accepted while it waits; a move produces no result.
module stack_segment_splice_table_top #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sst_pkg::FIELD_W-1:0] count_in_use_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [sst_pkg::FIELD_W-1:0] from_stack_i,
  input  logic [sst_pkg::FIELD_W-1:0] to_stack_i,
  input  logic [sst_pkg::FIELD_W-1:0] item_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sst_pkg::FIELD_W-1:0] holding_stack_o
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int IW = $clog2(MAX_ITEMS + 1);

  logic [sst_pkg::FIELD_W-1:0] count_q;

  logic          top_we, below_we;
  logic [AW-1:0] top_waddr, top_raddr, below_waddr, below_raddr;
  logic [IW-1:0] top_wdata, top_rdata, below_wdata, below_rdata;

  sst_pkg::sst_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= sst_pkg::COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= count_in_use_i;
    end
  end

  sst_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (IW)
  ) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (top_waddr),
    .wdata_i (top_wdata),
    .raddr_i (top_raddr),
    .rdata_o (top_rdata)
  );

  sst_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (IW)
  ) u_below_ram (
    .clk_i   (clk_i),
    .we_i    (below_we),
    .waddr_i (below_waddr),
    .wdata_i (below_wdata),
    .raddr_i (below_raddr),
    .rdata_o (below_rdata)
  );

  sst_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .count_i         (count_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .from_stack_i    (from_stack_i),
    .to_stack_i      (to_stack_i),
    .item_id_i       (item_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .holding_stack_o (holding_stack_o),
    .top_we_o        (top_we),
    .top_waddr_o     (top_waddr),
    .top_wdata_o     (top_wdata),
    .top_raddr_o     (top_raddr),
    .top_rdata_i     (top_rdata),
    .below_we_o      (below_we),
    .below_waddr_o   (below_waddr),
    .below_wdata_o   (below_wdata),
    .below_raddr_o   (below_raddr),
    .below_rdata_i   (below_rdata),
    .status_o        (status)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> in_stall_o)
    else $error("input accepted during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(status.locating))
    else $error("result raised without a locate in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (holding_stack_o <= count_q))
    else $error("reported stack outside the scanned range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i == sst_pkg::CMD_MOVE
     && item_id_i != '0 && from_stack_i != '0 && to_stack_i != '0
     && 32'(item_id_i) <= MAX_ITEMS && 32'(from_stack_i) <= MAX_ITEMS
     && 32'(to_stack_i) <= MAX_ITEMS)
    |=> status.moving ##1 status.moving ##1 status.moving ##1 !in_stall_o)
    else $error("move transaction did not follow its read-modify-write sequence");

endmodule
